// ===== rtl/core/bsac_pkg.sv =====
// Package for the barometer sample accumulate and compensate unit.
// Holds the sequencer states, the multiply step codes and the fixed constants.
// No dependencies.
package bsac_pkg;

    localparam int ADC_W  = 24;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 20;
    localparam int IDX_W  = 3;
    localparam int CAL_W  = 16;
    localparam int AVG_W  = 32;
    localparam int MUL_W  = 35;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 80;

    localparam logic [IDX_W-1:0] REG_CAL_SENS     = 3'd0;
    localparam logic [IDX_W-1:0] REG_CAL_OFF      = 3'd1;
    localparam logic [IDX_W-1:0] REG_CAL_TCS      = 3'd2;
    localparam logic [IDX_W-1:0] REG_CAL_TCO      = 3'd3;
    localparam logic [IDX_W-1:0] REG_CAL_TREF     = 3'd4;
    localparam logic [IDX_W-1:0] REG_CAL_TEMPSENS = 3'd5;
    localparam logic [IDX_W-1:0] REG_MIN_INTERVAL = 3'd6;

    localparam logic [CFG_W-1:0] MIN_INTERVAL_RESET = 20'd9500;
    localparam logic [31:0]      TEMP_CENTI_OFFSET  = 32'd2000;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CLR,
        S_DT,
        S_MUL,
        S_ACC,
        S_FIN,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_TEMP,
        OP_OFF,
        OP_SENS,
        OP_DT2,
        OP_TSQ,
        OP_PHI,
        OP_PLO
    } op_t;

endpackage

// ===== rtl/core/baro_sample_accumulate_compensate_unit.sv =====
// Barometer sample accumulator with first- and second-order compensation.
// One sequencer drives a shared restoring divider and a shared 35x35 multiplier.
// Depends on bsac_pkg.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------
//  cfg     | in        | cfg_we                  | cfg_index, cfg_data
//  in      | in        | in_valid / in_ready     | cmd, time_us, adc_value
//  out     | out       | out_valid / out_ready   | kind, accepted, next_convert, fresh,
//          |           |                         | temperature_centi, pressure_pa,
//          |           |                         | pressure_samples, raw_pressure,
//          |           |                         | raw_temperature
//
// A tick item goes straight to the output register. A read item with fresh data
// divides each non-empty sum into DIV_W quotient bits (DIV_W = 41 at default
// limits), one bit a cycle, then clears the sums; every read then runs the
// multiplier steps (S_MUL, S_ACC), S_FIN and S_OUT. in_ready is low while a
// read is worked on and while the output register holds an item nobody has taken.
// Reset clears the sequencer, the sums and the calibration registers and sets the
// minimum interval to 9500; the datapath and output registers are not reset.
module baro_sample_accumulate_compensate_unit #(
    parameter int TEMP_SUM_LIMIT  = 32,
    parameter int PRESS_SUM_LIMIT = 128,
    parameter int PRESS_PER_TEMP  = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bsac_pkg::IDX_W-1:0]        cfg_index,
    input  logic [bsac_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd,
    input  logic [bsac_pkg::TIME_W-1:0]       time_us,
    input  logic [bsac_pkg::ADC_W-1:0]        adc_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              kind,
    output logic                              accepted,
    output logic                              next_convert,
    output logic                              fresh,
    output logic signed [31:0]                temperature_centi,
    output logic signed [31:0]                pressure_pa,
    output logic [7:0]                        pressure_samples,
    output logic [bsac_pkg::ADC_W-1:0]        raw_pressure,
    output logic [bsac_pkg::ADC_W-1:0]        raw_temperature
);

    localparam int TCNT_W  = $clog2(TEMP_SUM_LIMIT + 1);
    localparam int PCNT_W  = $clog2(PRESS_SUM_LIMIT + 1);
    localparam int TSUM_W  = bsac_pkg::ADC_W + TCNT_W + 1;
    localparam int PSUM_W  = bsac_pkg::ADC_W + PCNT_W + 1;
    localparam int SUM_W   = (TSUM_W > PSUM_W) ? TSUM_W : PSUM_W;
    localparam int CNT_W   = (TCNT_W > PCNT_W) ? TCNT_W : PCNT_W;
    localparam int DIV_W   = SUM_W + 8;
    localparam int DCNT_W  = $clog2(DIV_W + 1);
    localparam int PHASE_W = $clog2(PRESS_PER_TEMP + 1);

    localparam logic [TCNT_W-1:0]  TCNT_LIMIT = TCNT_W'(TEMP_SUM_LIMIT);
    localparam logic [TCNT_W-1:0]  TCNT_HALF  = TCNT_W'(TEMP_SUM_LIMIT / 2);
    localparam logic [PCNT_W-1:0]  PCNT_LIMIT = PCNT_W'(PRESS_SUM_LIMIT);
    localparam logic [PCNT_W-1:0]  PCNT_HALF  = PCNT_W'(PRESS_SUM_LIMIT / 2);
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PRESS_PER_TEMP);
    localparam logic [DCNT_W-1:0]  DCNT_LAST  = DCNT_W'(DIV_W - 1);

    // configuration
    logic [bsac_pkg::CAL_W-1:0] cal_sens_reg, cal_off_reg, cal_tcs_reg;
    logic [bsac_pkg::CAL_W-1:0] cal_tco_reg, cal_tref_reg, cal_tempsens_reg;
    logic [bsac_pkg::CFG_W-1:0] min_interval_reg;

    // accumulator state
    logic [bsac_pkg::TIME_W-1:0] last_tick_reg;
    logic [PHASE_W-1:0]          phase_reg;
    logic [TSUM_W-1:0]           tsum_reg;
    logic [TCNT_W-1:0]           tcnt_reg;
    logic [PSUM_W-1:0]           psum_reg;
    logic [PCNT_W-1:0]           pcnt_reg;
    logic                        fresh_reg;
    logic [bsac_pkg::AVG_W-1:0]  avg_press_reg, avg_temp_reg;
    logic [7:0]                  last_psamp_reg;

    bsac_pkg::state_t state_reg, state_next;
    bsac_pkg::op_t    op_reg, op_next;
    logic             div_sel_reg;   // 0 pressure, 1 temperature
    logic [DCNT_W-1:0] div_cnt_reg;
    logic             out_valid_reg;

    // datapath
    logic [DIV_W-1:0]         quo_reg;
    logic [CNT_W-1:0]         rem_reg;
    logic signed [33:0]       dt_reg;
    logic [32:0]              mag_reg;
    logic signed [63:0]       temp_reg, off_reg, sens_reg;
    logic [24:0]              t2_reg;
    logic signed [bsac_pkg::PROD_W-1:0] prod_reg;
    logic signed [bsac_pkg::ACC_W-1:0]  acc_reg;
    logic                     rd_fresh_reg;

    logic                     kind_reg, accepted_reg, next_conv_reg, fresh_out_reg;
    logic signed [31:0]       temp_c_reg, press_pa_reg;
    logic [7:0]               psamp_out_reg;
    logic [bsac_pkg::ADC_W-1:0] raw_p_reg, raw_t_reg;

    logic in_fire, out_free, tick_fire, read_fire, throttled;
    logic [bsac_pkg::TIME_W-1:0] elapsed;
    logic [TSUM_W-1:0] tsum_add;
    logic [TCNT_W-1:0] tcnt_inc;
    logic [PSUM_W-1:0] psum_add;
    logic [PCNT_W-1:0] pcnt_inc;
    logic [PHASE_W-1:0] phase_inc;

    logic [CNT_W-1:0]  divisor;
    logic [CNT_W:0]    trial;
    logic              qbit;
    logic [CNT_W-1:0]  rem_step;
    logic [DIV_W-1:0]  quo_step;
    logic [bsac_pkg::AVG_W-1:0] avg_sat;
    logic              div_last, temp_div_next;

    logic signed [bsac_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [bsac_pkg::PROD_W-1:0] mul_p;
    logic signed [bsac_pkg::PROD_W-1:0] prod5;
    logic signed [63:0] x_val, diff_val;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == bsac_pkg::S_IDLE) && out_free;
    assign in_fire   = in_valid && in_ready;
    assign tick_fire = in_fire && (cmd == bsac_pkg::CMD_TICK);
    assign read_fire = in_fire && (cmd == bsac_pkg::CMD_READ);

    assign elapsed   = time_us - last_tick_reg;
    assign throttled = elapsed < {12'd0, min_interval_reg};
    assign tsum_add  = tsum_reg + TSUM_W'(adc_value);
    assign tcnt_inc  = tcnt_reg + TCNT_W'(1);
    assign psum_add  = psum_reg + PSUM_W'(adc_value);
    assign pcnt_inc  = pcnt_reg + PCNT_W'(1);
    assign phase_inc = phase_reg + PHASE_W'(1);

    // one restoring step of the shared divider
    assign divisor  = div_sel_reg ? CNT_W'(tcnt_reg) : CNT_W'(pcnt_reg);
    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign qbit     = trial >= {1'b0, divisor};
    assign rem_step = qbit ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
    assign quo_step = {quo_reg[DIV_W-2:0], qbit};
    assign avg_sat  = (|quo_step[DIV_W-1:bsac_pkg::AVG_W]) ? '1
                                                          : quo_step[bsac_pkg::AVG_W-1:0];
    assign div_last      = div_cnt_reg == DCNT_LAST;
    assign temp_div_next = !div_sel_reg && (tcnt_reg != '0);

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            bsac_pkg::OP_TEMP:
            begin
                mul_a = {dt_reg[33], dt_reg};
                mul_b = {19'd0, cal_tempsens_reg};
            end
            bsac_pkg::OP_OFF:
            begin
                mul_a = {dt_reg[33], dt_reg};
                mul_b = {19'd0, cal_tco_reg};
            end
            bsac_pkg::OP_SENS:
            begin
                mul_a = {dt_reg[33], dt_reg};
                mul_b = {19'd0, cal_tcs_reg};
            end
            bsac_pkg::OP_DT2:
            begin
                mul_a = {2'd0, mag_reg};
                mul_b = {2'd0, mag_reg};
            end
            bsac_pkg::OP_TSQ:
            begin
                mul_a = temp_reg[34:0];
                mul_b = temp_reg[34:0];
            end
            bsac_pkg::OP_PHI:
            begin
                mul_a = {3'd0, avg_press_reg};
                mul_b = sens_reg[58:24];
            end
            bsac_pkg::OP_PLO:
            begin
                mul_a = {3'd0, avg_press_reg};
                mul_b = {11'd0, sens_reg[23:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod5    = prod_reg + (prod_reg <<< 2);
    assign x_val    = 64'(acc_reg >>> 29);
    assign diff_val = x_val - off_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            bsac_pkg::S_IDLE:
            begin
                if (read_fire)
                begin
                    if (!fresh_reg)
                        state_next = bsac_pkg::S_DT;
                    else if (pcnt_reg != '0 || tcnt_reg != '0)
                        state_next = bsac_pkg::S_DIV;
                    else
                        state_next = bsac_pkg::S_CLR;
                end
            end
            bsac_pkg::S_DIV:
            begin
                if (div_last && !temp_div_next)
                    state_next = bsac_pkg::S_CLR;
            end
            bsac_pkg::S_CLR:
                state_next = bsac_pkg::S_DT;
            bsac_pkg::S_DT:
            begin
                state_next = bsac_pkg::S_MUL;
                op_next    = bsac_pkg::OP_TEMP;
            end
            bsac_pkg::S_MUL:
                state_next = bsac_pkg::S_ACC;
            bsac_pkg::S_ACC:
            begin
                state_next = bsac_pkg::S_MUL;
                case (op_reg)
                    bsac_pkg::OP_TEMP: op_next = bsac_pkg::OP_OFF;
                    bsac_pkg::OP_OFF:  op_next = bsac_pkg::OP_SENS;
                    bsac_pkg::OP_SENS: op_next = temp_reg[63] ? bsac_pkg::OP_DT2
                                                              : bsac_pkg::OP_PHI;
                    bsac_pkg::OP_DT2:  op_next = bsac_pkg::OP_TSQ;
                    bsac_pkg::OP_TSQ:  op_next = bsac_pkg::OP_PHI;
                    bsac_pkg::OP_PHI:  op_next = bsac_pkg::OP_PLO;
                    default:           state_next = bsac_pkg::S_FIN;
                endcase
            end
            bsac_pkg::S_FIN:
                state_next = bsac_pkg::S_OUT;
            bsac_pkg::S_OUT:
            begin
                if (out_free)
                    state_next = bsac_pkg::S_IDLE;
            end
            default:
                state_next = bsac_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bsac_pkg::S_IDLE;
            op_reg           <= bsac_pkg::OP_TEMP;
            cal_sens_reg     <= '0;
            cal_off_reg      <= '0;
            cal_tcs_reg      <= '0;
            cal_tco_reg      <= '0;
            cal_tref_reg     <= '0;
            cal_tempsens_reg <= '0;
            min_interval_reg <= bsac_pkg::MIN_INTERVAL_RESET;
            last_tick_reg    <= '0;
            phase_reg        <= '0;
            tsum_reg         <= '0;
            tcnt_reg         <= '0;
            psum_reg         <= '0;
            pcnt_reg         <= '0;
            fresh_reg        <= 1'b0;
            avg_press_reg    <= '0;
            avg_temp_reg     <= '0;
            last_psamp_reg   <= '0;
            div_sel_reg      <= 1'b0;
            div_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    bsac_pkg::REG_CAL_SENS:     cal_sens_reg     <= cfg_data[15:0];
                    bsac_pkg::REG_CAL_OFF:      cal_off_reg      <= cfg_data[15:0];
                    bsac_pkg::REG_CAL_TCS:      cal_tcs_reg      <= cfg_data[15:0];
                    bsac_pkg::REG_CAL_TCO:      cal_tco_reg      <= cfg_data[15:0];
                    bsac_pkg::REG_CAL_TREF:     cal_tref_reg     <= cfg_data[15:0];
                    bsac_pkg::REG_CAL_TEMPSENS: cal_tempsens_reg <= cfg_data[15:0];
                    bsac_pkg::REG_MIN_INTERVAL: min_interval_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (tick_fire || (state_reg == bsac_pkg::S_OUT && out_free))
                out_valid_reg <= 1'b1;

            if (tick_fire && !throttled)
            begin
                last_tick_reg <= time_us;
                if (phase_reg == '0)
                begin
                    if (tcnt_inc >= TCNT_LIMIT)
                    begin
                        tsum_reg <= tsum_add >> 1;
                        tcnt_reg <= TCNT_HALF;
                    end
                    else
                    begin
                        tsum_reg <= tsum_add;
                        tcnt_reg <= tcnt_inc;
                    end
                    phase_reg <= PHASE_W'(1);
                end
                else
                begin
                    if (pcnt_inc >= PCNT_LIMIT)
                    begin
                        psum_reg <= psum_add >> 1;
                        pcnt_reg <= PCNT_HALF;
                    end
                    else
                    begin
                        psum_reg <= psum_add;
                        pcnt_reg <= pcnt_inc;
                    end
                    fresh_reg <= 1'b1;
                    phase_reg <= (phase_reg >= PHASE_LAST) ? '0 : phase_inc;
                end
            end

            if (read_fire)
            begin
                div_sel_reg <= (pcnt_reg == '0);
                div_cnt_reg <= '0;
            end

            if (state_reg == bsac_pkg::S_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
                if (div_last)
                begin
                    if (div_sel_reg)
                        avg_temp_reg <= avg_sat;
                    else
                        avg_press_reg <= avg_sat;
                    if (temp_div_next)
                    begin
                        div_sel_reg <= 1'b1;
                        div_cnt_reg <= '0;
                    end
                end
            end

            if (state_reg == bsac_pkg::S_CLR)
            begin
                last_psamp_reg <= 8'(pcnt_reg);
                psum_reg       <= '0;
                tsum_reg       <= '0;
                pcnt_reg       <= '0;
                tcnt_reg       <= '0;
                fresh_reg      <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            kind_reg      <= bsac_pkg::KIND_TICK;
            accepted_reg  <= !throttled;
            fresh_out_reg <= 1'b0;
            temp_c_reg    <= '0;
            press_pa_reg  <= '0;
            psamp_out_reg <= '0;
            raw_p_reg     <= '0;
            raw_t_reg     <= '0;
            if (throttled)
                next_conv_reg <= (phase_reg == '0);
            else if (phase_reg == '0)
                next_conv_reg <= 1'b0;
            else
                next_conv_reg <= (phase_reg >= PHASE_LAST);
        end

        if (read_fire)
        begin
            rd_fresh_reg <= fresh_reg;
            rem_reg      <= '0;
            quo_reg      <= (pcnt_reg == '0) ? {DIV_W'(tsum_reg) << 8}
                                             : {DIV_W'(psum_reg) << 8};
        end

        case (state_reg)
            bsac_pkg::S_DIV:
            begin
                rem_reg <= rem_step;
                quo_reg <= quo_step;
                // load the temperature sum once the pressure average is out
                if (div_last && temp_div_next)
                begin
                    rem_reg <= '0;
                    quo_reg <= DIV_W'(tsum_reg) << 8;
                end
            end
            bsac_pkg::S_DT:
            begin
                dt_reg  <= $signed({2'd0, avg_temp_reg}) - $signed({2'd0, cal_tref_reg, 16'd0});
            end
            bsac_pkg::S_MUL:
            begin
                prod_reg <= mul_p;
                mag_reg  <= dt_reg[33] ? 33'(-dt_reg) : 33'(dt_reg);
            end
            bsac_pkg::S_ACC:
            begin
                case (op_reg)
                    bsac_pkg::OP_TEMP:
                        temp_reg <= 64'(prod_reg >>> 23);
                    bsac_pkg::OP_OFF:
                        off_reg  <= $signed({24'd0, cal_off_reg, 24'd0})
                                    + 64'(prod_reg >>> 7);
                    bsac_pkg::OP_SENS:
                        sens_reg <= $signed({25'd0, cal_sens_reg, 23'd0})
                                    + 64'(prod_reg >>> 8);
                    bsac_pkg::OP_DT2:
                        t2_reg   <= prod_reg[63:39];
                    bsac_pkg::OP_TSQ:
                    begin
                        off_reg  <= off_reg - 64'(prod5 >>> 9);
                        sens_reg <= sens_reg - 64'(prod5 >>> 10);
                        temp_reg <= temp_reg - $signed({39'd0, t2_reg});
                    end
                    bsac_pkg::OP_PHI:
                        acc_reg  <= {prod_reg[55:0], 24'd0};
                    bsac_pkg::OP_PLO:
                        acc_reg  <= acc_reg + bsac_pkg::ACC_W'(prod_reg);
                    default: ;
                endcase
            end
            bsac_pkg::S_FIN:
            begin
                press_pa_reg <= 32'(diff_val >>> 23);
                temp_c_reg   <= 32'(temp_reg >>> 8) + bsac_pkg::TEMP_CENTI_OFFSET;
            end
            bsac_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    kind_reg      <= bsac_pkg::KIND_READ;
                    accepted_reg  <= 1'b0;
                    next_conv_reg <= 1'b0;
                    fresh_out_reg <= rd_fresh_reg;
                    psamp_out_reg <= last_psamp_reg;
                    raw_p_reg     <= avg_press_reg[31:8];
                    raw_t_reg     <= avg_temp_reg[31:8];
                end
            end
            default: ;
        endcase
    end

    assign out_valid         = out_valid_reg;
    assign kind              = kind_reg;
    assign accepted          = accepted_reg;
    assign next_convert      = next_conv_reg;
    assign fresh             = fresh_out_reg;
    assign temperature_centi = temp_c_reg;
    assign pressure_pa       = press_pa_reg;
    assign pressure_samples  = psamp_out_reg;
    assign raw_pressure      = raw_p_reg;
    assign raw_temperature   = raw_t_reg;

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for baro_sample_accumulate_compensate_unit.
// Drives ticks, reads and register writes, predicts each result and checks it.
// Depends on bsac_pkg and the unit itself.
module tb;

    localparam logic [bsac_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 150;

    typedef struct packed {
        logic        kind;
        logic        accepted;
        logic        next_convert;
        logic        fresh;
        logic [31:0] temperature_centi;
        logic [31:0] pressure_pa;
        logic [7:0]  pressure_samples;
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } baro_res_t;

    logic clk, rst_n;
    logic cfg_we;
    logic [bsac_pkg::IDX_W-1:0] cfg_index;
    logic [bsac_pkg::CFG_W-1:0] cfg_data;
    logic in_valid, in_ready, cmd;
    logic [bsac_pkg::TIME_W-1:0] time_us;
    logic [bsac_pkg::ADC_W-1:0] adc_value;
    logic out_valid, out_ready;
    logic kind, accepted, next_convert, fresh;
    logic signed [31:0] temperature_centi, pressure_pa;
    logic [7:0] pressure_samples;
    logic [bsac_pkg::ADC_W-1:0] raw_pressure, raw_temperature;

    baro_sample_accumulate_compensate_unit uut (.*);

    // predictor copy of calibration and accumulator state
    logic [15:0] k_sens, k_off, k_tcs, k_tco, k_tref, k_tsens;
    logic [19:0] k_interval;
    logic [31:0] p_last_tick, p_tsum, p_psum, p_avg_p, p_avg_t;
    logic [2:0]  p_phase;
    logic [7:0]  p_tcount, p_pcount, p_last_samples;
    logic        p_fresh;

    baro_res_t expected_q[$];
    int errors = 0;
    int cycles = 0;
    logic [31:0] now_us = 0;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [31:0] q8_average(logic [31:0] sum, logic [7:0] cnt);
        logic [63:0] v;
        v = {24'b0, sum, 8'b0} / cnt;
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic baro_res_t compensate_step(logic c, logic [31:0] now,
                                                  logic [23:0] adc);
        baro_res_t r;
        longint dt, tv, off, sens, tsq, t2, x, pv;
        longint unsigned mag;
        logic signed [127:0] wide;
        r = '0;
        if (c == bsac_pkg::CMD_TICK) begin
            r.kind = bsac_pkg::KIND_TICK;
            if ((now - p_last_tick) < {12'b0, k_interval}) begin
                r.next_convert = (p_phase == 0);
                return r;
            end
            p_last_tick = now;
            r.accepted = 1'b1;
            if (p_phase == 0) begin
                p_tsum = p_tsum + adc;
                p_tcount++;
                if (p_tcount >= 32) begin
                    p_tsum = p_tsum >> 1;
                    p_tcount = 16;
                end
                p_phase = 1;
            end else begin
                p_psum = p_psum + adc;
                p_pcount++;
                if (p_pcount >= 128) begin
                    p_psum = p_psum >> 1;
                    p_pcount = 64;
                end
                p_phase++;
                p_fresh = 1'b1;
                if (p_phase >= 5) begin
                    p_phase = 0;
                    r.next_convert = 1'b1;
                end
            end
            return r;
        end
        r.kind = bsac_pkg::KIND_READ;
        r.fresh = p_fresh;
        if (p_fresh) begin
            if (p_pcount != 0) p_avg_p = q8_average(p_psum, p_pcount);
            if (p_tcount != 0) p_avg_t = q8_average(p_tsum, p_tcount);
            p_last_samples = p_pcount;
            p_psum = 0;
            p_tsum = 0;
            p_pcount = 0;
            p_tcount = 0;
            p_fresh = 1'b0;
        end
        dt = longint'({32'b0, p_avg_t}) - (longint'({48'b0, k_tref}) << 16);
        tv = (dt * longint'({48'b0, k_tsens})) >>> 23;
        off = (longint'({48'b0, k_off}) << 24) + ((longint'({48'b0, k_tco}) * dt) >>> 7);
        sens = (longint'({48'b0, k_sens}) << 23) + ((longint'({48'b0, k_tcs}) * dt) >>> 8);
        if (tv < 0) begin
            mag = (dt < 0) ? -dt : dt;
            t2 = longint'((mag * mag) >> 39);
            tsq = tv * tv;
            off -= (5 * tsq) >>> 9;
            sens -= (5 * tsq) >>> 10;
            tv -= t2;
        end
        wide = $signed({96'b0, p_avg_p}) * $signed({{64{sens[63]}}, sens});
        wide = wide >>> 29;
        x = wide[63:0];
        pv = (x - off) >>> 23;
        tv = (tv >>> 8) + 2000;
        r.temperature_centi = tv[31:0];
        r.pressure_pa = pv[31:0];
        r.pressure_samples = p_last_samples;
        r.raw_pressure = p_avg_p[31:8];
        r.raw_temperature = p_avg_t[31:8];
        return r;
    endfunction

    task automatic send_item(logic c, logic [31:0] t, logic [23:0] adc);
        int gap;
        in_valid <= 1'b1;
        cmd <= c;
        time_us <= t;
        adc_value <= adc;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        expected_q.push_back(compensate_step(c, t, adc));
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold until every result is in and the unit has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [bsac_pkg::IDX_W-1:0] idx, logic [bsac_pkg::CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            bsac_pkg::REG_CAL_SENS:     k_sens = val[15:0];
            bsac_pkg::REG_CAL_OFF:      k_off = val[15:0];
            bsac_pkg::REG_CAL_TCS:      k_tcs = val[15:0];
            bsac_pkg::REG_CAL_TCO:      k_tco = val[15:0];
            bsac_pkg::REG_CAL_TREF:     k_tref = val[15:0];
            bsac_pkg::REG_CAL_TEMPSENS: k_tsens = val[15:0];
            bsac_pkg::REG_MIN_INTERVAL: k_interval = val;
            default: ;
        endcase
    endtask

    task automatic write_cal(logic [15:0] s, logic [15:0] o, logic [15:0] tcs,
                             logic [15:0] tco, logic [15:0] tref, logic [15:0] ts,
                             logic [19:0] ivl);
        drain();
        write_reg(bsac_pkg::REG_CAL_SENS, {4'b0, s});
        write_reg(bsac_pkg::REG_CAL_OFF, {4'b0, o});
        write_reg(bsac_pkg::REG_CAL_TCS, {4'b0, tcs});
        write_reg(bsac_pkg::REG_CAL_TCO, {4'b0, tco});
        write_reg(bsac_pkg::REG_CAL_TREF, {4'b0, tref});
        write_reg(bsac_pkg::REG_CAL_TEMPSENS, {4'b0, ts});
        write_reg(bsac_pkg::REG_MIN_INTERVAL, ivl);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // one tick that clears the throttle
    task automatic tick(logic [23:0] adc);
        now_us = now_us + k_interval + $urandom_range(0, 40);
        send_item(bsac_pkg::CMD_TICK, now_us, adc);
    endtask

    task automatic test_reset_state();
        send_item(bsac_pkg::CMD_READ, $urandom, 24'($urandom));
        send_item(bsac_pkg::CMD_TICK, 32'd0, 24'hFFFFFF);
        send_item(bsac_pkg::CMD_TICK, 32'd9499, 24'h000001);
        now_us = 32'd9500;
        send_item(bsac_pkg::CMD_TICK, now_us, 24'h800000);
        send_item(bsac_pkg::CMD_READ, 32'd0, 24'd0);
    endtask

    task automatic test_directed();
        write_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 20'd0);
        tick(24'hFFFFFF);
        repeat (4) tick(24'h000000);
        send_item(bsac_pkg::CMD_READ, now_us, 24'h0);
        send_item(bsac_pkg::CMD_READ, now_us, 24'h0);
        // throttled tick just inside the interval, then time wrap
        write_cal(16'd40000, 16'd36000, 16'd23000, 16'd21000, 16'hFFFF, 16'd28000,
                  20'd1000000);
        now_us = 32'hFFFF_FF00;
        send_item(bsac_pkg::CMD_TICK, now_us, 24'h123456);
        send_item(bsac_pkg::CMD_TICK, now_us + 32'd999_999, 24'hABCDEF);
        tick(24'h000000);
        tick(24'hFFFFFF);
        send_item(bsac_pkg::CMD_READ, now_us, 24'hFFFFFF);
        drain();
        write_reg(REG_UNUSED, 20'hFFFFF);
        cfg_we <= 1'b0;
        @(posedge clk);
        write_cal(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 20'd9500);
        tick(24'h555555);
        send_item(bsac_pkg::CMD_READ, now_us, 24'hAAAAAA);
    endtask

    // run both counts past their limits so the halving path is taken
    task automatic test_sum_limits();
        write_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312, 20'd3);
        repeat (180) tick(24'hFFFFFF - 24'($urandom_range(0, 255)));
        send_item(bsac_pkg::CMD_READ, now_us, 24'd0);
        repeat (170) tick(24'($urandom));
        send_item(bsac_pkg::CMD_READ, now_us, 24'd0);
    endtask

    task automatic test_random_traffic();
        logic [31:0] adc;
        for (int ph = 0; ph < 6; ph++) begin
            write_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      (ph == 1) ? 16'hFFFF : 16'($urandom), 16'($urandom),
                      (ph == 5) ? 20'd999_999 : 20'($urandom_range(0, 20000)));
            for (int n = 0; n < 250; n++) begin
                adc = $urandom;
                case ($urandom_range(0, 19))
                    0: send_item(bsac_pkg::CMD_READ, $urandom, adc[23:0]);
                    1: send_item(bsac_pkg::CMD_TICK, now_us + $urandom_range(0, k_interval),
                                 adc[23:0]);
                    2: begin
                        now_us = $urandom;
                        send_item(bsac_pkg::CMD_TICK, now_us, adc[23:0]);
                    end
                    3: tick($urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000);
                    default: tick(adc[23:0]);
                endcase
            end
        end
    endtask

    // receiver: stall at random, check each result against the oldest expectation
    initial begin
        baro_res_t e;
        int w;
        out_ready <= 1'b0;
        @(posedge clk);
        forever begin
            w = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w > 0) begin
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(negedge clk); while (!out_valid);
            if (expected_q.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (kind !== e.kind) begin
                    $error("kind exp %0d got %0d", e.kind, kind); errors++;
                end
                if (accepted !== e.accepted) begin
                    $error("accepted exp %0d got %0d", e.accepted, accepted); errors++;
                end
                if (next_convert !== e.next_convert) begin
                    $error("next_convert exp %0d got %0d", e.next_convert, next_convert);
                    errors++;
                end
                if (fresh !== e.fresh) begin
                    $error("fresh exp %0d got %0d", e.fresh, fresh); errors++;
                end
                if (temperature_centi !== e.temperature_centi) begin
                    $error("temperature_centi exp %0d got %0d",
                           $signed(e.temperature_centi), temperature_centi);
                    errors++;
                end
                if (pressure_pa !== e.pressure_pa) begin
                    $error("pressure_pa exp %0d got %0d", $signed(e.pressure_pa), pressure_pa);
                    errors++;
                end
                if (pressure_samples !== e.pressure_samples) begin
                    $error("pressure_samples exp %0d got %0d",
                           e.pressure_samples, pressure_samples);
                    errors++;
                end
                if (raw_pressure !== e.raw_pressure) begin
                    $error("raw_pressure exp %0d got %0d", e.raw_pressure, raw_pressure);
                    errors++;
                end
                if (raw_temperature !== e.raw_temperature) begin
                    $error("raw_temperature exp %0d got %0d",
                           e.raw_temperature, raw_temperature);
                    errors++;
                end
            end
            @(posedge clk);
        end
    end

    initial begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= bsac_pkg::REG_CAL_SENS;
        cfg_data <= '0;
        in_valid <= 1'b0;
        cmd <= bsac_pkg::CMD_TICK;
        time_us <= '0;
        adc_value <= '0;
        {k_sens, k_off, k_tcs, k_tco, k_tref, k_tsens} = '0;
        k_interval = bsac_pkg::MIN_INTERVAL_RESET;
        {p_last_tick, p_tsum, p_psum, p_avg_p, p_avg_t} = '0;
        p_phase = 0;
        {p_tcount, p_pcount, p_last_samples} = '0;
        p_fresh = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_directed();
        test_sum_limits();
        test_random_traffic();
        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/bsac_pkg.sv
rtl/core/baro_sample_accumulate_compensate_unit.sv
bench/tb.sv
